// ===== rtl/core/gmu_pkg.sv =====
`default_nettype none

package gmu_pkg;

  localparam int unsigned XW = 34;
  localparam int unsigned DW = 33;
  localparam int unsigned RW = 32;
  localparam int unsigned NW = 6;
  localparam int unsigned GAP_RECIP = 32'hCCCC_CCCD;

  typedef enum logic [2:0] {
    OP_STEP      = 3'd0,
    OP_GAP       = 3'd1,
    OP_UNIFORM   = 3'd2,
    OP_POW2      = 3'd3,
    OP_POW2_ZERO = 3'd4,
    OP_BOOL      = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [XW-1:0] gene;
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] gap;
    logic [NW-1:0]        n;
    logic                 empty;
  } ctx_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [RW-1:0] rnd;
    logic [DW-1:0] dvs;
    ctx_t          ctx;
  } cell_t;

endpackage

`default_nettype wire

// ===== rtl/core/gmu_mod_cell.sv =====
`default_nettype none

module gmu_mod_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire gmu_pkg::cell_t cell_i,
  output logic               valid_o,
  output gmu_pkg::cell_t     cell_o
);

  logic [gmu_pkg::DW:0] trial;
  logic [gmu_pkg::DW:0] dvs_x;
  gmu_pkg::cell_t       cell_d;
  gmu_pkg::cell_t       cell_q;
  logic                 valid_q;

  always_comb begin
    trial  = {cell_i.rem, cell_i.rnd[gmu_pkg::RW-1]};
    dvs_x  = {1'b0, cell_i.dvs};
    cell_d = cell_i;
    cell_d.rnd = {cell_i.rnd[gmu_pkg::RW-2:0], 1'b0};
    if (trial >= dvs_x) begin
      cell_d.rem = gmu_pkg::DW'(trial - dvs_x);
    end else begin
      cell_d.rem = trial[gmu_pkg::DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

`default_nettype wire

// ===== rtl/core/gmu_prep.sv =====
`default_nettype none

module gmu_prep #(
  parameter int unsigned IW = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] gene_i,
  input  wire logic [31:0] lo_i,
  input  wire logic [31:0] hi_i,
  input  wire logic [31:0] rnd_i,
  output logic             valid_o,
  output gmu_pkg::cell_t   cell_o
);

  localparam int unsigned XW = gmu_pkg::XW;

  logic signed [XW-1:0] gene_x, lo_x, hi_x;
  logic [30:0]          ge_d;
  logic [63:0]          lo64;

  logic                 s1_v_q;
  logic [2:0]           s1_op_q;
  logic signed [XW-1:0] s1_gene_q, s1_lo_q, s1_hi_q, s1_diff_q;
  logic [31:0]          s1_rnd_q;
  logic [30:0]          s1_ge_q;

  logic [XW-1:0]        mag;
  logic [31:0]          quar;

  logic                 s2_v_q;
  logic [2:0]           s2_op_q;
  logic signed [XW-1:0] s2_gene_q, s2_lo_q, s2_hi_q, s2_diff_q;
  logic [31:0]          s2_rnd_q;
  logic [63:0]          s2_prod_q;
  logic                 s2_neg_q;
  logic [gmu_pkg::NW-1:0] s2_n_q;

  logic signed [XW-1:0] gap, span2, spanu;
  gmu_pkg::cell_t       cell_d;
  gmu_pkg::cell_t       cell_q;
  logic                 valid_q;

  assign gene_x = {{(XW-IW){gene_i[IW-1]}}, gene_i[IW-1:0]};
  assign lo_x   = {{(XW-IW){lo_i[IW-1]}}, lo_i[IW-1:0]};
  assign hi_x   = {{(XW-IW){hi_i[IW-1]}}, hi_i[IW-1:0]};
  assign lo64   = 64'(lo_x[31:0]);

  always_comb begin
    for (int k = 1; k < 32; k++) begin
      ge_d[k-1] = !hi_x[XW-1] && ((lo64 << k) <= 64'(hi_x[31:0]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q   <= op_i;
      s1_gene_q <= gene_x;
      s1_lo_q   <= lo_x;
      s1_hi_q   <= hi_x;
      s1_rnd_q  <= rnd_i;
      s1_diff_q <= hi_x - lo_x;
      s1_ge_q   <= ge_d;
    end
  end

  assign mag  = s1_diff_q[XW-1] ? XW'(-s1_diff_q) : XW'(s1_diff_q);
  assign quar = 32'(mag >> 2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_op_q   <= s1_op_q;
      s2_gene_q <= s1_gene_q;
      s2_lo_q   <= s1_lo_q;
      s2_hi_q   <= s1_hi_q;
      s2_rnd_q  <= s1_rnd_q;
      s2_diff_q <= s1_diff_q;
      s2_prod_q <= 64'(quar) * 64'(32'(gmu_pkg::GAP_RECIP));
      s2_neg_q  <= s1_diff_q[XW-1];
      s2_n_q    <= gmu_pkg::NW'($countones(s1_ge_q));
    end
  end

  always_comb begin
    gap = s2_neg_q ? -XW'(s2_prod_q[63:34]) : XW'(s2_prod_q[63:34]);
    if (gap == '0) begin
      gap = XW'(1);
    end
    span2 = gap <<< 1;
    spanu = s2_diff_q + XW'(1);

    cell_d.rem       = '0;
    cell_d.rnd       = s2_rnd_q;
    cell_d.ctx.op    = s2_op_q;
    cell_d.ctx.gene  = s2_gene_q;
    cell_d.ctx.lo    = s2_lo_q;
    cell_d.ctx.hi    = s2_hi_q;
    cell_d.ctx.gap   = gap;
    cell_d.ctx.n     = s2_n_q;
    cell_d.ctx.empty = 1'b0;
    cell_d.dvs       = gmu_pkg::DW'(1);
    case (s2_op_q)
      gmu_pkg::OP_STEP: cell_d.dvs = gmu_pkg::DW'(2);
      gmu_pkg::OP_GAP: begin
        cell_d.ctx.empty = (span2 <= 0);
        if (span2 > 0) cell_d.dvs = span2[gmu_pkg::DW-1:0];
      end
      gmu_pkg::OP_UNIFORM: begin
        cell_d.ctx.empty = (spanu <= 0);
        if (spanu > 0) cell_d.dvs = spanu[gmu_pkg::DW-1:0];
      end
      gmu_pkg::OP_POW2:      cell_d.dvs = gmu_pkg::DW'(s2_n_q) + gmu_pkg::DW'(1);
      gmu_pkg::OP_POW2_ZERO: cell_d.dvs = gmu_pkg::DW'(s2_n_q) + gmu_pkg::DW'(2);
      default:               cell_d.dvs = gmu_pkg::DW'(1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q  <= valid_i;
      s2_v_q  <= s1_v_q;
      valid_q <= s2_v_q;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

`default_nettype wire

// ===== rtl/core/gmu_post.sv =====
`default_nettype none

module gmu_post #(
  parameter int unsigned IW = 32
) (
  input  wire gmu_pkg::cell_t cell_i,
  output logic [31:0]         new_gene_o,
  output logic                error_o
);

  localparam int unsigned EW = 36;

  logic signed [EW-1:0] gene, lo, hi, gap, off, res, jump;
  logic [31:0]          pow;
  logic [2:0]           op;

  always_comb begin
    op   = cell_i.ctx.op;
    gene = EW'(cell_i.ctx.gene);
    lo   = EW'(cell_i.ctx.lo);
    hi   = EW'(cell_i.ctx.hi);
    gap  = EW'(cell_i.ctx.gap);
    off  = cell_i.ctx.empty ? '0 : EW'(cell_i.rem);
    pow  = cell_i.ctx.lo[31:0] << cell_i.rem[4:0];
    jump = gene + off - gap;
    res  = gene;
    error_o = 1'b0;
    case (op)
      gmu_pkg::OP_STEP: begin
        if (gene == lo) res = gene + EW'(1);
        else if (gene == hi) res = gene - EW'(1);
        else if (cell_i.rem[0]) res = gene + EW'(1);
        else res = gene - EW'(1);
      end
      gmu_pkg::OP_GAP: begin
        if (jump < lo) res = lo;
        else if (jump > hi) res = hi;
        else res = jump;
      end
      gmu_pkg::OP_UNIFORM: res = lo + off;
      gmu_pkg::OP_POW2: begin
        if (lo <= 0) error_o = 1'b1;
        else res = EW'(pow);
      end
      gmu_pkg::OP_POW2_ZERO: begin
        if (lo <= 0) error_o = 1'b1;
        else if (cell_i.rem == 33'(cell_i.ctx.n) + 33'd1) res = '0;
        else res = EW'(pow);
      end
      gmu_pkg::OP_BOOL: res = (gene == 0) ? EW'(1) : '0;
      default: error_o = 1'b1;
    endcase
    if (error_o) res = gene;
  end

  if (IW >= 32) begin : g_full
    assign new_gene_o = res[31:0];
  end else begin : g_narrow
    assign new_gene_o = {{(32-IW){res[IW-1]}}, res[IW-1:0]};
  end

endmodule

`default_nettype wire

// ===== rtl/core/ga_gene_mutation_unit.sv =====
// datapath: input word to result word through 3 setup stages, 32 remainder cells and combinational
// result logic into the output register; throughput: one word per cycle while the output is not stalled,
// the chain of 32 restoring remainder cells retiring one dividend bit per cell per cycle
// reset: rst_ni asynchronous active low clears all valid flags; the data registers are not reset
`default_nettype none

module ga_gene_mutation_unit #(
  parameter int unsigned GENE_WIDTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // operation, gene_value, lower_bound, upper_bound, random_word
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // new_gene
  output logic              m_axis_tuser   // error
);

  localparam int unsigned IW = (GENE_WIDTH < 32) ? GENE_WIDTH : 32;
  localparam int unsigned NC = gmu_pkg::RW;

  logic           en;
  logic           v_c [NC+1];
  gmu_pkg::cell_t c_c [NC+1];
  logic [31:0]    gene_d;
  logic           err_d;
  logic [31:0]    gene_q;
  logic           err_q;
  logic           valid_q;

  assign en            = !valid_q || m_axis_tready;
  assign s_axis_tready = en;

  gmu_prep #(.IW(IW)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .op_i    (s_axis_tdata[2:0]),
    .gene_i  (s_axis_tdata[34:3]),
    .lo_i    (s_axis_tdata[66:35]),
    .hi_i    (s_axis_tdata[98:67]),
    .rnd_i   (s_axis_tdata[130:99]),
    .valid_o (v_c[0]),
    .cell_o  (c_c[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    gmu_mod_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_c[i]),
      .cell_i  (c_c[i]),
      .valid_o (v_c[i+1]),
      .cell_o  (c_c[i+1])
    );
  end

  gmu_post #(.IW(IW)) u_post (
    .cell_i     (c_c[NC]),
    .new_gene_o (gene_d),
    .error_o    (err_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= v_c[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gene_q <= gene_d;
      err_q  <= err_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = gene_q;
  assign m_axis_tuser  = err_q;

endmodule

`default_nettype wire

// ===== verif/tb_ga_gene_mutation_unit.sv =====
`timescale 1ns / 100ps

module tb_ga_gene_mutation_unit;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 1650;
  localparam int unsigned PAUSE_AT = 700;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [31:0] gene;
    logic        err;
  } mutation_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;  // operation, gene_value, lower_bound, upper_bound, random_word
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;  // new_gene
  logic         m_axis_tuser;  // error

  logic [135:0] pending_q[$];
  mutation_t    mutation_q[$];
  int unsigned  words_in, words_out, mismatches, idle_cycles;
  int unsigned  burst_left, gap_left, stall_mode, stall_left;
  int unsigned  op_seen[8];
  bit           stim_done;

  ga_gene_mutation_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint pick(longint lo, longint span, longint unsigned r);
    if (span <= 0) return lo;
    return lo + longint'(r % longint'(span));
  endfunction

  function automatic mutation_t mutate(logic [135:0] w);
    logic [2:0]      op;
    longint          g, l, h, res, gap, n, k, q;
    longint unsigned r;
    mutation_t       m;
    op  = w[2:0];
    g   = longint'($signed(w[34:3]));
    l   = longint'($signed(w[66:35]));
    h   = longint'($signed(w[98:67]));
    r   = longint'(w[130:99]);
    res = g;
    m.err = 1'b0;
    case (op) inside
      gmu_pkg::OP_STEP: begin
        if (g == l) res = g + 1;
        else if (g == h) res = g - 1;
        else res = g + ((pick(0, 2, r) > 0) ? 1 : -1);
      end
      gmu_pkg::OP_GAP: begin
        gap = (h - l) / 20;
        if (gap == 0) gap = 1;
        res = g + pick(0, 2 * gap, r) - gap;
        if (res < l) res = l;
        else if (res > h) res = h;
      end
      gmu_pkg::OP_UNIFORM: res = pick(l, h + 1 - l, r);
      gmu_pkg::OP_POW2, gmu_pkg::OP_POW2_ZERO: begin
        if (l <= 0) begin
          m.err = 1'b1;
        end else begin
          q = h / l;
          n = 0;
          while (q > 1) begin
            q = q / 2;
            n++;
          end
          k = pick(0, (op == gmu_pkg::OP_POW2) ? n + 1 : n + 2, r);
          res = (k == n + 1) ? 0 : (l << k);
        end
      end
      gmu_pkg::OP_BOOL: res = (g == 0) ? 1 : 0;
      default: m.err = 1'b1;
    endcase
    if (m.err) res = g;
    m.gene = res[31:0];
    return m;
  endfunction

  function automatic logic [135:0] pack_req(logic [2:0] op, logic [31:0] g, logic [31:0] l,
                                            logic [31:0] h, logic [31:0] r);
    return {5'b0, r, h, l, g, op};
  endfunction

  task automatic add_random();
    logic [2:0]  op;
    logic [31:0] g, l, h, r;
    longint      span, lo;
    op = 3'($urandom_range(0, 7));
    if (op > 5 && $urandom_range(0, 3) != 0) op = 3'($urandom_range(0, 5));
    r = $urandom();
    if ($urandom_range(0, 9) < 2) begin
      g = $urandom();
      l = $urandom();
      h = $urandom();
    end else begin
      case ($urandom_range(0, 3))
        0: span = $urandom_range(0, 8);
        1: span = $urandom_range(0, 200);
        2: span = $urandom_range(0, 100000);
        default: span = longint'($urandom()) & 64'h7FFF_FFFF;
      endcase
      if (op == gmu_pkg::OP_POW2 || op == gmu_pkg::OP_POW2_ZERO) lo = $urandom_range(1, 5000);
      else lo = longint'($signed($urandom())) / (1 << $urandom_range(0, 20));
      if (lo + span > INT_MAX) lo = INT_MAX - span;
      l = lo[31:0];
      h = 32'(lo + span);
      case ($urandom_range(0, 5))
        0: g = l;
        1: g = h;
        2: g = 0;
        default: g = 32'(lo + longint'($urandom()) % (span + 1));
      endcase
    end
    pending_q.push_back(pack_req(op, g, l, h, r));
  endtask

  initial begin
    pending_q.push_back(pack_req(gmu_pkg::OP_STEP, 5, 5, 9, 0));
    pending_q.push_back(pack_req(gmu_pkg::OP_STEP, 9, 5, 9, 1));
    pending_q.push_back(pack_req(gmu_pkg::OP_STEP, 7, 5, 9, 1));
    pending_q.push_back(pack_req(gmu_pkg::OP_STEP, 7, 5, 9, 2));
    pending_q.push_back(pack_req(gmu_pkg::OP_STEP, INT_MAX, 0, 0, 1));
    pending_q.push_back(pack_req(gmu_pkg::OP_STEP, INT_MIN, 0, 0, 0));
    pending_q.push_back(pack_req(gmu_pkg::OP_GAP, 100, 0, 1000, 32'hFFFF_FFFF));
    pending_q.push_back(pack_req(gmu_pkg::OP_GAP, 3, 0, 5, 0));
    pending_q.push_back(pack_req(gmu_pkg::OP_GAP, 0, INT_MIN, INT_MAX, 32'hFFFF_FFFF));
    pending_q.push_back(pack_req(gmu_pkg::OP_GAP, 50, 100, 10, 7));
    pending_q.push_back(pack_req(gmu_pkg::OP_GAP, 5, 100, 10, 7));
    pending_q.push_back(pack_req(gmu_pkg::OP_UNIFORM, 0, INT_MIN, INT_MAX, 32'hFFFF_FFFF));
    pending_q.push_back(pack_req(gmu_pkg::OP_UNIFORM, 0, 20, 10, 123));
    pending_q.push_back(pack_req(gmu_pkg::OP_POW2, 9, 0, 100, 5));
    pending_q.push_back(pack_req(gmu_pkg::OP_POW2, 9, -5, 100, 5));
    pending_q.push_back(pack_req(gmu_pkg::OP_POW2, 9, 1, INT_MAX, 32'hFFFF_FFFF));
    pending_q.push_back(pack_req(gmu_pkg::OP_POW2, 9, 3, INT_MAX, 29));
    pending_q.push_back(pack_req(gmu_pkg::OP_POW2, 9, 50, 10, 3));
    pending_q.push_back(pack_req(gmu_pkg::OP_POW2_ZERO, 9, 4, 64, 5));
    pending_q.push_back(pack_req(gmu_pkg::OP_POW2_ZERO, 9, 50, 10, 1));
    pending_q.push_back(pack_req(gmu_pkg::OP_POW2_ZERO, 9, INT_MIN, 10, 1));
    pending_q.push_back(pack_req(gmu_pkg::OP_BOOL, 0, 0, 0, 0));
    pending_q.push_back(pack_req(gmu_pkg::OP_BOOL, INT_MIN, 0, 0, 0));
    pending_q.push_back(pack_req(OP_RSVD6, 42, 0, 1, 0));
    pending_q.push_back(pack_req(OP_RSVD7, INT_MAX, 0, 1, 0));
    repeat (N_RANDOM) add_random();
    stim_done = 1'b1;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && pending_q.size() == 0 && mutation_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("%0d words sent, %0d results checked, %0d mismatches", words_in, words_out,
             mismatches);
    $display("per mode: %0d %0d %0d %0d %0d %0d %0d %0d", op_seen[0], op_seen[1], op_seen[2],
             op_seen[3], op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
    if (mismatches == 0 && mutation_q.size() == 0) begin
      $display("tb_ga_gene_mutation_unit passed");
    end else begin
      $display("tb_ga_gene_mutation_unit failed");
    end
    $finish;
  end

  // sender in bursts, with one pause until the pipe drains
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        void'(pending_q.pop_front());
        mutation_q.push_back(mutate(s_axis_tdata));
        op_seen[s_axis_tdata[2:0]]++;
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if ((words_in == PAUSE_AT && mutation_q.size() != 0) || gap_left != 0 ||
            pending_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern and word checking
  always @(posedge clk_i or negedge rst_ni) begin
    mutation_t exp_m;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
      stall_left    <= 0;
      idle_cycles   <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (mutation_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: gene %h err %b", m_axis_tdata,
                                         m_axis_tuser);
        end else begin
          exp_m = mutation_q.pop_front();
          if (m_axis_tdata !== exp_m.gene || m_axis_tuser !== exp_m.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected gene %h err %b, got gene %h err %b", words_out,
                       exp_m.gene, exp_m.err, m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 15) == 0);
      endcase
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", mutation_q.size());
        $display("tb_ga_gene_mutation_unit failed");
        $finish;
      end
    end
  end

endmodule
